// ----- rtl/iasu_pkg.sv -----
// Shared types, command codes and lane helpers for the integer/packed add-sub unit.
// No dependencies; imported by every module of the unit.
package iasu_pkg;

   localparam int HALF_W         = 64;
   localparam int BYTES_PER_HALF = HALF_W / 8;
   localparam int BYTE_IDX_W     = $clog2(BYTES_PER_HALF);
   localparam int CMD_W          = 5;
   localparam int IMM_W          = 16;

   // Operation codes
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD    = 5'd0,
      CMD_ADDI   = 5'd1,
      CMD_ADDIU  = 5'd2,
      CMD_ADDU   = 5'd3,
      CMD_DADD   = 5'd4,
      CMD_DADDI  = 5'd5,
      CMD_DADDIU = 5'd6,
      CMD_DADDU  = 5'd7,
      CMD_DSUB   = 5'd8,
      CMD_DSUBU  = 5'd9,
      CMD_SUB    = 5'd10,
      CMD_SUBU   = 5'd11,
      CMD_PADDB  = 5'd12,
      CMD_PADDH  = 5'd13,
      CMD_PADDSB = 5'd14,
      CMD_PADDSH = 5'd15,
      CMD_PADDSW = 5'd16,
      CMD_PADDUB = 5'd17,
      CMD_PADDUH = 5'd18,
      CMD_PADDUW = 5'd19,
      CMD_PADDW  = 5'd20,
      CMD_PADSBH = 5'd21,
      CMD_PSUBB  = 5'd22,
      CMD_PSUBH  = 5'd23,
      CMD_PSUBSB = 5'd24,
      CMD_PSUBSH = 5'd25,
      CMD_PSUBSW = 5'd26,
      CMD_PSUBUB = 5'd27,
      CMD_PSUBUH = 5'd28,
      CMD_PSUBUW = 5'd29,
      CMD_PSUBW  = 5'd30
   } cmd_type;

   typedef enum logic [1:0] {
      LANE_8  = 2'd0,
      LANE_16 = 2'd1,
      LANE_32 = 2'd2,
      LANE_64 = 2'd3
   } lane_w_type;

   typedef enum logic [1:0] {
      MODE_WRAP = 2'd0,
      MODE_SSAT = 2'd1,
      MODE_USAT = 2'd2
   } mode_type;

   // Decoded control that travels down the pipeline
   typedef struct packed {
      lane_w_type lane_w;
      mode_type   mode;
      logic       sub_lo;    // subtract in low 64 bits
      logic       sub_hi;    // subtract in high 64 bits
      logic       use_imm;   // sign-extended immediate replaces operand b
      logic       scalar;    // scalar form, high half not written
      logic       scalar32;  // 32-bit scalar, result sign-extended
      logic       trap_en;   // signed overflow traps
      logic       nop;       // unused code, all outputs zero
   } ctrl_type;

   // Per-byte status from a 64-bit partitioned adder
   typedef struct packed {
      logic [BYTES_PER_HALF-1:0] cout;    // carry out of each byte
      logic [BYTES_PER_HALF-1:0] ovf;     // signed overflow if byte is a lane top
      logic [BYTES_PER_HALF-1:0] a_sign;  // sign bit of operand a byte
   } add_flags_type;

   // First byte of a lane
   function automatic logic lane_start(input logic [BYTE_IDX_W-1:0] idx,
                                       input lane_w_type lane_w);
      logic r;
      case (lane_w)
         LANE_8:  r = 1'b1;
         LANE_16: r = (idx[0] == 1'b0);
         LANE_32: r = (idx[1:0] == 2'b00);
         default: r = (idx == '0);
      endcase
      return r;
   endfunction

   // Index of the top byte of the lane that holds byte idx
   function automatic logic [BYTE_IDX_W-1:0] lane_top(input logic [BYTE_IDX_W-1:0] idx,
                                                      input lane_w_type lane_w);
      logic [BYTE_IDX_W-1:0] r;
      case (lane_w)
         LANE_8:  r = idx;
         LANE_16: r = idx | BYTE_IDX_W'(1);
         LANE_32: r = idx | BYTE_IDX_W'(3);
         default: r = '1;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/iasu_decode.sv -----
// Command decoder: maps the 5-bit operation code to pipeline control.
// Depends on iasu_pkg.
module iasu_decode
   import iasu_pkg::*;
(
   input  logic [CMD_W-1:0] command,
   output ctrl_type         ctrl
);

   // Lane width, mode and form
   always_comb begin
      ctrl = '{lane_w: LANE_8, mode: MODE_WRAP, sub_lo: 1'b0, sub_hi: 1'b0,
               use_imm: 1'b0, scalar: 1'b0, scalar32: 1'b0, trap_en: 1'b0,
               nop: 1'b0};
      unique case (command) inside
         CMD_ADD, CMD_ADDI, CMD_ADDIU, CMD_ADDU, CMD_SUB, CMD_SUBU: begin
            ctrl.lane_w   = LANE_32;
            ctrl.scalar   = 1'b1;
            ctrl.scalar32 = 1'b1;
         end
         CMD_DADD, CMD_DADDI, CMD_DADDIU, CMD_DADDU, CMD_DSUB, CMD_DSUBU: begin
            ctrl.lane_w = LANE_64;
            ctrl.scalar = 1'b1;
         end
         CMD_PADDB, CMD_PSUBB:   ctrl.lane_w = LANE_8;
         CMD_PADDH, CMD_PSUBH:   ctrl.lane_w = LANE_16;
         CMD_PADDW, CMD_PSUBW:   ctrl.lane_w = LANE_32;
         CMD_PADSBH:             ctrl.lane_w = LANE_16;
         CMD_PADDSB, CMD_PSUBSB: begin
            ctrl.lane_w = LANE_8;
            ctrl.mode   = MODE_SSAT;
         end
         CMD_PADDSH, CMD_PSUBSH: begin
            ctrl.lane_w = LANE_16;
            ctrl.mode   = MODE_SSAT;
         end
         CMD_PADDSW, CMD_PSUBSW: begin
            ctrl.lane_w = LANE_32;
            ctrl.mode   = MODE_SSAT;
         end
         CMD_PADDUB, CMD_PSUBUB: begin
            ctrl.lane_w = LANE_8;
            ctrl.mode   = MODE_USAT;
         end
         CMD_PADDUH, CMD_PSUBUH: begin
            ctrl.lane_w = LANE_16;
            ctrl.mode   = MODE_USAT;
         end
         CMD_PADDUW, CMD_PSUBUW: begin
            ctrl.lane_w = LANE_32;
            ctrl.mode   = MODE_USAT;
         end
         default: ctrl.nop = 1'b1;
      endcase

      // Subtract forms; mixed form subtracts low half only
      case (command) inside
         CMD_SUB, CMD_SUBU, CMD_DSUB, CMD_DSUBU, CMD_PSUBB, CMD_PSUBH, CMD_PSUBSB,
         CMD_PSUBSH, CMD_PSUBSW, CMD_PSUBUB, CMD_PSUBUH, CMD_PSUBUW, CMD_PSUBW: begin
            ctrl.sub_lo = 1'b1;
            ctrl.sub_hi = 1'b1;
         end
         CMD_PADSBH: ctrl.sub_lo = 1'b1;
         default: ;
      endcase

      // Immediate forms
      case (command) inside
         CMD_ADDI, CMD_ADDIU, CMD_DADDI, CMD_DADDIU: ctrl.use_imm = 1'b1;
         default: ;
      endcase

      // Trapping forms
      case (command) inside
         CMD_ADD, CMD_ADDI, CMD_SUB, CMD_DADD, CMD_DADDI, CMD_DSUB: ctrl.trap_en = 1'b1;
         default: ;
      endcase
   end

endmodule

// ----- rtl/iasu_lane_adder.sv -----
// 64-bit partitioned adder: byte slices with carries cut at lane boundaries.
// Depends on iasu_pkg.
module iasu_lane_adder
   import iasu_pkg::*;
(
   input  logic [HALF_W-1:0] operand_a,
   input  logic [HALF_W-1:0] operand_b,
   input  logic              sub,
   input  lane_w_type        lane_w,
   output logic [HALF_W-1:0] sum,
   output add_flags_type     flags
);

   // Ripple over byte slices; a lane start takes sub as carry in
   always_comb begin
      logic       carry;
      logic       cin;
      logic [7:0] xa;
      logic [7:0] xb;
      logic [8:0] s;
      carry = 1'b0;
      for (int i = 0; i < BYTES_PER_HALF; i++) begin
         xa  = operand_a[8*i +: 8];
         xb  = operand_b[8*i +: 8] ^ {8{sub}};
         cin = lane_start(BYTE_IDX_W'(i), lane_w) ? sub : carry;
         s   = {1'b0, xa} + {1'b0, xb} + {8'd0, cin};
         sum[8*i +: 8]   = s[7:0];
         flags.cout[i]   = s[8];
         flags.ovf[i]    = (xa[7] == xb[7]) && (s[7] != xa[7]);
         flags.a_sign[i] = xa[7];
         carry           = s[8];
      end
   end

endmodule

// ----- rtl/iasu_saturate.sv -----
// Lane saturation for one 64-bit half: signed or unsigned clamp per lane.
// Depends on iasu_pkg.
module iasu_saturate
   import iasu_pkg::*;
(
   input  logic [HALF_W-1:0] sum,
   input  add_flags_type     flags,
   input  logic              sub,
   input  lane_w_type        lane_w,
   input  mode_type          mode,
   output logic [HALF_W-1:0] result
);

   // Each byte looks at the status of its lane's top byte
   always_comb begin
      logic [BYTE_IDX_W-1:0] t;
      logic                  is_top;
      for (int i = 0; i < BYTES_PER_HALF; i++) begin
         t      = lane_top(BYTE_IDX_W'(i), lane_w);
         is_top = (t == BYTE_IDX_W'(i));
         result[8*i +: 8] = sum[8*i +: 8];
         case (mode)
            MODE_USAT: begin
               if (!sub && flags.cout[t]) result[8*i +: 8] = 8'hFF;
               if (sub && !flags.cout[t]) result[8*i +: 8] = 8'h00;
            end
            MODE_SSAT: begin
               if (flags.ovf[t]) begin
                  if (flags.a_sign[t]) result[8*i +: 8] = is_top ? 8'h80 : 8'h00;
                  else                 result[8*i +: 8] = is_top ? 8'h7F : 8'hFF;
               end
            end
            default: ;
         endcase
      end
   end

endmodule

// ----- rtl/integer_and_packed_add_sub_unit.sv -----
// Integer and packed add/subtract unit, three register stages.
// rsp_tvalid rises once a request has passed the stage 1, stage 2 and stage 3 registers.
// Throughput one transaction per cycle while rsp_tready is not held low.
// Stage 1 decodes and selects operands, stage 2 runs the partitioned adders,
// stage 3 saturates and formats. Backpressure stalls only stages that are full.
// Reset (synchronous, active high) clears the stage valid bits; data registers are not reset.
// Depends on iasu_pkg, iasu_decode, iasu_lane_adder, iasu_saturate.
module integer_and_packed_add_sub_unit
   import iasu_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   // req_tdata: command[4:0], operand_a_low[68:5], operand_a_high[132:69],
   //            operand_b_low[196:133], operand_b_high[260:197], immediate[276:261]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [279:0] req_tdata,
   // rsp_tdata: result_low[63:0], result_high[127:64]
   // rsp_tuser: high_written[0], overflow_trap[1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,
   output logic [1:0]   rsp_tuser
);

   // Input unpacking
   logic [CMD_W-1:0]  req_command;
   logic [HALF_W-1:0] req_a_low, req_a_high, req_b_low, req_b_high;
   logic [IMM_W-1:0]  req_immediate;

   assign req_command   = req_tdata[4:0];
   assign req_a_low     = req_tdata[68:5];
   assign req_a_high    = req_tdata[132:69];
   assign req_b_low     = req_tdata[196:133];
   assign req_b_high    = req_tdata[260:197];
   assign req_immediate = req_tdata[276:261];

   // Stage handshake
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in;
   logic s1_ready, s2_ready, s3_ready;

   assign s3_ready   = !s3_valid_ff || rsp_tready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   // Stage 1: decode and operand select
   ctrl_type          dec_ctrl;
   ctrl_type          s1_ctrl_ff, s1_ctrl_in;
   logic [HALF_W-1:0] s1_a_lo_ff, s1_a_hi_ff, s1_b_lo_ff, s1_b_hi_ff;
   logic [HALF_W-1:0] s1_a_lo_in, s1_a_hi_in, s1_b_lo_in, s1_b_hi_in;

   iasu_decode u_decode (
      .command (req_command),
      .ctrl    (dec_ctrl)
   );

   assign s1_valid_in = s1_ready ? req_tvalid : s1_valid_ff;
   assign s1_ctrl_in  = dec_ctrl;
   assign s1_a_lo_in  = req_a_low;
   assign s1_a_hi_in  = req_a_high;
   assign s1_b_lo_in  = dec_ctrl.use_imm ?
                        {{(HALF_W-IMM_W){req_immediate[IMM_W-1]}}, req_immediate} :
                        req_b_low;
   assign s1_b_hi_in  = req_b_high;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tvalid && s1_ready) begin
         s1_ctrl_ff <= s1_ctrl_in;
         s1_a_lo_ff <= s1_a_lo_in;
         s1_a_hi_ff <= s1_a_hi_in;
         s1_b_lo_ff <= s1_b_lo_in;
         s1_b_hi_ff <= s1_b_hi_in;
      end
   end

   // Stage 2: partitioned adders, one per half
   logic [HALF_W-1:0] add_sum_lo, add_sum_hi;
   add_flags_type     add_flags_lo, add_flags_hi;
   ctrl_type          s2_ctrl_ff;
   logic [HALF_W-1:0] s2_sum_lo_ff, s2_sum_hi_ff;
   add_flags_type     s2_flags_lo_ff, s2_flags_hi_ff;

   iasu_lane_adder u_add_lo (
      .operand_a (s1_a_lo_ff),
      .operand_b (s1_b_lo_ff),
      .sub       (s1_ctrl_ff.sub_lo),
      .lane_w    (s1_ctrl_ff.lane_w),
      .sum       (add_sum_lo),
      .flags     (add_flags_lo)
   );

   iasu_lane_adder u_add_hi (
      .operand_a (s1_a_hi_ff),
      .operand_b (s1_b_hi_ff),
      .sub       (s1_ctrl_ff.sub_hi),
      .lane_w    (s1_ctrl_ff.lane_w),
      .sum       (add_sum_hi),
      .flags     (add_flags_hi)
   );

   assign s2_valid_in = s2_ready ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
      if (s1_valid_ff && s2_ready) begin
         s2_ctrl_ff     <= s1_ctrl_ff;
         s2_sum_lo_ff   <= add_sum_lo;
         s2_sum_hi_ff   <= add_sum_hi;
         s2_flags_lo_ff <= add_flags_lo;
         s2_flags_hi_ff <= add_flags_hi;
      end
   end

   // Stage 3: saturation and result formatting
   logic [HALF_W-1:0] sat_lo, sat_hi;
   logic              scalar_ovf;
   logic [HALF_W-1:0] res_lo_in, res_hi_in;
   logic              hw_in, trap_in;
   logic [HALF_W-1:0] s3_res_lo_ff, s3_res_hi_ff;
   logic              s3_hw_ff, s3_trap_ff;

   iasu_saturate u_sat_lo (
      .sum    (s2_sum_lo_ff),
      .flags  (s2_flags_lo_ff),
      .sub    (s2_ctrl_ff.sub_lo),
      .lane_w (s2_ctrl_ff.lane_w),
      .mode   (s2_ctrl_ff.mode),
      .result (sat_lo)
   );

   iasu_saturate u_sat_hi (
      .sum    (s2_sum_hi_ff),
      .flags  (s2_flags_hi_ff),
      .sub    (s2_ctrl_ff.sub_hi),
      .lane_w (s2_ctrl_ff.lane_w),
      .mode   (s2_ctrl_ff.mode),
      .result (sat_hi)
   );

   // Scalar overflow comes from the top byte of the low word or doubleword
   assign scalar_ovf = s2_ctrl_ff.scalar32 ? s2_flags_lo_ff.ovf[3] :
                                             s2_flags_lo_ff.ovf[BYTES_PER_HALF-1];

   always_comb begin
      res_lo_in = '0;
      res_hi_in = '0;
      hw_in     = 1'b0;
      trap_in   = 1'b0;
      if (s2_ctrl_ff.nop) begin
         res_lo_in = '0;
      end else if (s2_ctrl_ff.scalar) begin
         trap_in = s2_ctrl_ff.trap_en && scalar_ovf;
         if (trap_in)                  res_lo_in = '0;
         else if (s2_ctrl_ff.scalar32) res_lo_in = {{32{s2_sum_lo_ff[31]}}, s2_sum_lo_ff[31:0]};
         else                          res_lo_in = s2_sum_lo_ff;
      end else begin
         res_lo_in = sat_lo;
         res_hi_in = sat_hi;
         hw_in     = 1'b1;
      end
   end

   assign s3_valid_in = s3_ready ? s2_valid_ff : s3_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
      if (s2_valid_ff && s3_ready) begin
         s3_res_lo_ff <= res_lo_in;
         s3_res_hi_ff <= res_hi_in;
         s3_hw_ff     <= hw_in;
         s3_trap_ff   <= trap_in;
      end
   end

   // Output
   assign rsp_tvalid = s3_valid_ff;
   assign rsp_tdata  = {s3_res_hi_ff, s3_res_lo_ff};
   assign rsp_tuser  = {s3_trap_ff, s3_hw_ff};

`ifndef SYNTHESIS
   // A trapped transaction never writes any destination bits
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0] && rsp_tdata == '0)
      else $error("trapped result carries data");

   // Scalar results leave the high half zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata[127:64] == '0)
      else $error("scalar result has nonzero high half");

   // A stalled stage 2 item stays put
   assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !s3_ready |=> s2_valid_ff && $stable(s2_sum_lo_ff)
                                   && $stable(s2_sum_hi_ff))
      else $error("stage 2 item lost during stall");

   // An accepted request always occupies stage 1 next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid_ff)
      else $error("accepted request dropped");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for integer_and_packed_add_sub_unit: scalar, trapping and packed
// add/subtract forms driven over the req stream and checked against an in-bench predictor.
// Depends on iasu_pkg and the unit's RTL only.
`timescale 1ns / 100ps

module testbench;
   import iasu_pkg::*;

   // Code 31 has no operation and must produce an all-zero result
   localparam logic [CMD_W-1:0] CMD_UNUSED = 5'd31;
   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [63:0] lo;
      logic [63:0] hi;
      logic        high_written;
      logic        overflow_trap;
   } dest_value_type;

   logic         clock      = 1'b0;
   logic         reset      = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [279:0] req_tdata  = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [127:0] rsp_tdata;
   logic [1:0]   rsp_tuser;

   dest_value_type expected_results[$];
   int failures    = 0;
   int idle_cycles = 0;
   int rx_stall    = 0;
   int rx_calm     = 0;
   int tx_calm     = 0;

   integer_and_packed_add_sub_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Idle length: mostly none or short, a few long, with calm stretches of no idling
   function automatic int idle_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm = $urandom_range(20, 120);
         return 0;
      end
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // One lane-wise operation over a 64-bit half
   function automatic logic [63:0] lane_calc(input logic [63:0] a, input logic [63:0] b,
                                             input int w, input logic do_sub,
                                             input mode_type mode);
      logic [63:0] r;
      longint mask, half, x, y, v;
      r    = '0;
      mask = (longint'(1) << w) - 1;
      half = longint'(1) << (w - 1);
      for (int sh = 0; sh < 64; sh += w) begin
         x = longint'((a >> sh) & mask);
         y = longint'((b >> sh) & mask);
         case (mode)
            MODE_USAT: begin
               if (do_sub) v = (x < y) ? 0 : x - y;
               else        v = (x + y > mask) ? mask : x + y;
            end
            MODE_SSAT: begin
               if (x >= half) x -= mask + 1;
               if (y >= half) y -= mask + 1;
               v = do_sub ? x - y : x + y;
               if (v > half - 1) v = half - 1;
               if (v < -half)    v = -half;
            end
            default: v = do_sub ? x - y : x + y;
         endcase
         r |= (64'(v) & 64'(mask)) << sh;
      end
      return r;
   endfunction

   // Destination value and flags for one command
   function automatic dest_value_type compute_add_sub(
      input logic [CMD_W-1:0] cmd,
      input logic [63:0] a_lo, input logic [63:0] a_hi,
      input logic [63:0] b_lo, input logic [63:0] b_hi,
      input logic [IMM_W-1:0] imm);
      dest_value_type d;
      logic [63:0] imm_ext, y64, s64, ov64;
      logic [31:0] x32, y32, s32, ov32;
      int          w;
      logic        do_sub, lanes;
      mode_type    mode;
      d       = '{lo: '0, hi: '0, high_written: 1'b0, overflow_trap: 1'b0};
      imm_ext = {{48{imm[15]}}, imm};
      w       = 8;
      do_sub  = 1'b0;
      mode    = MODE_WRAP;
      lanes   = 1'b1;
      case (cmd) inside
         CMD_ADD, CMD_ADDI, CMD_ADDIU, CMD_ADDU, CMD_SUB, CMD_SUBU: begin
            x32    = a_lo[31:0];
            y32    = (cmd == CMD_ADDI || cmd == CMD_ADDIU) ? imm_ext[31:0] : b_lo[31:0];
            do_sub = (cmd == CMD_SUB || cmd == CMD_SUBU);
            s32    = do_sub ? x32 - y32 : x32 + y32;
            ov32   = do_sub ? (x32 ^ y32) & (x32 ^ s32) : (x32 ^ s32) & (y32 ^ s32);
            d.overflow_trap = (cmd == CMD_ADD || cmd == CMD_ADDI || cmd == CMD_SUB) && ov32[31];
            d.lo   = d.overflow_trap ? 64'd0 : {{32{s32[31]}}, s32};
            lanes  = 1'b0;
         end
         CMD_DADD, CMD_DADDI, CMD_DADDIU, CMD_DADDU, CMD_DSUB, CMD_DSUBU: begin
            y64    = (cmd == CMD_DADDI || cmd == CMD_DADDIU) ? imm_ext : b_lo;
            do_sub = (cmd == CMD_DSUB || cmd == CMD_DSUBU);
            s64    = do_sub ? a_lo - y64 : a_lo + y64;
            ov64   = do_sub ? (a_lo ^ y64) & (a_lo ^ s64) : (a_lo ^ s64) & (y64 ^ s64);
            d.overflow_trap = (cmd == CMD_DADD || cmd == CMD_DADDI || cmd == CMD_DSUB) && ov64[63];
            d.lo   = d.overflow_trap ? 64'd0 : s64;
            lanes  = 1'b0;
         end
         // mixed form: subtract halfwords of the low half, add halfwords of the high half
         CMD_PADSBH: begin
            d.lo           = lane_calc(a_lo, b_lo, 16, 1'b1, MODE_WRAP);
            d.hi           = lane_calc(a_hi, b_hi, 16, 1'b0, MODE_WRAP);
            d.high_written = 1'b1;
            lanes          = 1'b0;
         end
         CMD_PADDB:  w = 8;
         CMD_PADDH:  w = 16;
         CMD_PADDW:  w = 32;
         CMD_PADDSB: begin w = 8;  mode = MODE_SSAT; end
         CMD_PADDSH: begin w = 16; mode = MODE_SSAT; end
         CMD_PADDSW: begin w = 32; mode = MODE_SSAT; end
         CMD_PADDUB: begin w = 8;  mode = MODE_USAT; end
         CMD_PADDUH: begin w = 16; mode = MODE_USAT; end
         CMD_PADDUW: begin w = 32; mode = MODE_USAT; end
         CMD_PSUBB:  begin w = 8;  do_sub = 1'b1; end
         CMD_PSUBH:  begin w = 16; do_sub = 1'b1; end
         CMD_PSUBW:  begin w = 32; do_sub = 1'b1; end
         CMD_PSUBSB: begin w = 8;  do_sub = 1'b1; mode = MODE_SSAT; end
         CMD_PSUBSH: begin w = 16; do_sub = 1'b1; mode = MODE_SSAT; end
         CMD_PSUBSW: begin w = 32; do_sub = 1'b1; mode = MODE_SSAT; end
         CMD_PSUBUB: begin w = 8;  do_sub = 1'b1; mode = MODE_USAT; end
         CMD_PSUBUH: begin w = 16; do_sub = 1'b1; mode = MODE_USAT; end
         CMD_PSUBUW: begin w = 32; do_sub = 1'b1; mode = MODE_USAT; end
         default:    lanes = 1'b0;
      endcase
      if (lanes) begin
         d.lo           = lane_calc(a_lo, b_lo, w, do_sub, mode);
         d.hi           = lane_calc(a_hi, b_hi, w, do_sub, mode);
         d.high_written = 1'b1;
      end
      return d;
   endfunction

   // Operand with lanes of a random width set to boundary or random values, or fully random
   function automatic logic [63:0] rand_operand();
      logic [63:0] v, mask, lane;
      int          w;
      if ($urandom_range(0, 3) == 0) return {$urandom, $urandom};
      v    = '0;
      w    = 8 << $urandom_range(0, 3);
      mask = (w == 64) ? '1 : ((64'd1 << w) - 1);
      for (int sh = 0; sh < 64; sh += w) begin
         case ($urandom_range(0, 5))
            0:       lane = '0;
            1:       lane = 64'd1;
            2:       lane = mask >> 1;
            3:       lane = mask ^ (mask >> 1);
            4:       lane = mask;
            default: lane = {$urandom, $urandom};
         endcase
         v |= (lane & mask) << sh;
      end
      return v;
   endfunction

   function automatic logic [IMM_W-1:0] rand_immediate();
      case ($urandom_range(0, 15))
         0:       return 16'h8000;
         1:       return 16'h7FFF;
         2:       return 16'hFFFF;
         3:       return 16'h0000;
         4:       return 16'h0001;
         default: return IMM_W'($urandom);
      endcase
   endfunction

   // Send one transaction and queue its expected result once accepted
   task automatic send_op(input logic [CMD_W-1:0] cmd,
                          input logic [63:0] a_lo, input logic [63:0] a_hi,
                          input logic [63:0] b_lo, input logic [63:0] b_hi,
                          input logic [IMM_W-1:0] imm);
      int gap;
      gap = idle_len(tx_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, imm, b_hi, b_lo, a_hi, a_lo, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_results.push_back(compute_add_sub(cmd, a_lo, a_hi, b_lo, b_hi, imm));
   endtask

   // Result checker and random backpressure
   always @(posedge clock) begin
      dest_value_type exp_v;
      int             n;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with no expected result pending");
            failures++;
         end else begin
            exp_v = expected_results.pop_front();
            if (rsp_tdata[63:0] !== exp_v.lo) begin
               $error("result_low: expected %h, got %h", exp_v.lo, rsp_tdata[63:0]);
               failures++;
            end
            if (rsp_tdata[127:64] !== exp_v.hi) begin
               $error("result_high: expected %h, got %h", exp_v.hi, rsp_tdata[127:64]);
               failures++;
            end
            if (rsp_tuser[0] !== exp_v.high_written) begin
               $error("high_written: expected %b, got %b", exp_v.high_written, rsp_tuser[0]);
               failures++;
            end
            if (rsp_tuser[1] !== exp_v.overflow_trap) begin
               $error("overflow_trap: expected %b, got %b", exp_v.overflow_trap, rsp_tuser[1]);
               failures++;
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rx_stall > 0) begin
         rx_stall--;
         rsp_tready <= 1'b0;
      end else begin
         n = idle_len(rx_calm);
         rsp_tready <= (n == 0);
         rx_stall = (n > 0) ? n - 1 : 0;
      end
   end

   // Watchdog: too long without any transaction on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("integer_and_packed_add_sub_unit: mismatch");
         $finish;
      end
   end

   // Every code once, including the unused one, with boundary operands
   task automatic test_every_command();
      logic [63:0]      pats[4];
      logic [IMM_W-1:0] imms[4];
      pats = '{64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_8000_8080, 64'h7FFF_FFFF_7FFF_7F7F};
      imms = '{16'h8000, 16'h7FFF, 16'hFFFF, 16'h0000};
      for (int i = 0; i <= CMD_UNUSED; i++)
         send_op(CMD_W'(i), pats[i % 4], pats[(i + 2) % 4], pats[(i + 1) % 4],
                 pats[(i + 3) % 4], imms[i % 4]);
   endtask

   // Signed overflow on the trapping forms and on non-trapping ADDU, subtraction checked as subtraction
   task automatic test_overflow_traps();
      send_op(CMD_ADD,   64'hAAAA_AAAA_7FFF_FFFF, '1, 64'h5555_5555_0000_0001, '1, 16'h0);
      send_op(CMD_ADDU,  64'h0000_0000_7FFF_FFFF, '0, 64'h1, '0, 16'h0);
      send_op(CMD_SUB,   64'h0000_0000_8000_0000, '0, 64'h1, '0, 16'h0);
      send_op(CMD_SUB,   64'h0, '0, 64'h0000_0000_8000_0000, '0, 16'h0);
      send_op(CMD_ADDI,  64'hFFFF_FFFF_8000_0000, '0, '1, '0, 16'h8000);
      send_op(CMD_DADD,  64'h7FFF_FFFF_FFFF_FFFF, '0, 64'h1, '0, 16'h0);
      send_op(CMD_DSUB,  64'h8000_0000_0000_0000, '0, 64'h1, '0, 16'h0);
      send_op(CMD_DADDI, 64'h8000_0000_0000_0000, '0, '0, '0, 16'hFFFF);
   endtask

   // Random commands and operands, with correlated second operands now and then
   task automatic test_random_traffic(input int count);
      logic [63:0] a_lo, a_hi, b_lo, b_hi;
      for (int i = 0; i < count; i++) begin
         a_lo = rand_operand();
         a_hi = rand_operand();
         case ($urandom_range(0, 7))
            0:       begin b_lo = a_lo;  b_hi = a_hi;  end
            1:       begin b_lo = ~a_lo; b_hi = ~a_hi; end
            default: begin b_lo = rand_operand(); b_hi = rand_operand(); end
         endcase
         send_op(CMD_W'($urandom_range(0, CMD_UNUSED)), a_lo, a_hi, b_lo, b_hi,
                 rand_immediate());
      end
   endtask

   // Burst, let the pipeline empty completely, then resume
   task automatic test_drain_and_resume();
      test_random_traffic(40);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      test_random_traffic(40);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_every_command();
      test_overflow_traps();
      test_random_traffic(500);
      test_drain_and_resume();
      test_random_traffic(500);
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0)
         $display("integer_and_packed_add_sub_unit: match");
      else
         $display("integer_and_packed_add_sub_unit: mismatch");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/iasu_pkg.sv
rtl/iasu_decode.sv
rtl/iasu_lane_adder.sv
rtl/iasu_saturate.sv
rtl/integer_and_packed_add_sub_unit.sv
test/testbench.sv
